@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL, empty when synthesising
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/core/x86alu_pkg.sv @@
// Types and constants of the 8086-style ALU with flag update
`timescale 1ns / 1ps

package x86alu_pkg;

    // Operation codes carried in the input transaction
    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_OR  = 4'd1,
        OP_AND = 4'd2,
        OP_SUB = 4'd3,
        OP_XOR = 4'd4,
        OP_CMP = 4'd5,
        OP_INC = 4'd6,
        OP_DEC = 4'd7,
        OP_ROL = 4'd8,
        OP_ROR = 4'd9,
        OP_SHL = 4'd10,
        OP_SHR = 4'd11,
        OP_SAR = 4'd12
    } t_alu_op;

    // How the flag word is rewritten at the last stage
    typedef enum logic [1:0] {
        FM_KEEP  = 2'd0,   // flags pass through unchanged
        FM_ARITH = 2'd1,   // O S Z P C replaced, A cleared
        FM_LOGIC = 2'd2    // O S Z P C replaced, A kept
    } t_flag_mode;

    localparam int WORD_W = 16;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 8;

    // Flag word bit positions
    localparam int FL_O = 11;
    localparam int FL_S = 7;
    localparam int FL_Z = 6;
    localparam int FL_A = 4;
    localparam int FL_P = 2;
    localparam int FL_C = 1;

endpackage

@@ rtl/core/x86_alu_with_flags.sv @@
// Top level: three-stage pipelined 8086-style ALU with flag update
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The block takes one ALU transaction per clock while the output side is
// ready and returns one result transaction for each, in order, after it
// has passed the three register stages (operand decode, adder and
// shifter, flag assembly). When the output is stalled the stages fill up
// and input ready falls only once all three hold a transaction.
// Operations: add, or, and, sub, xor, cmp, inc, dec, rol, ror, shl, shr,
// sar on bytes or words; unused codes return the destination and the
// flags unchanged with write-back low.
module x86_alu_with_flags
    import x86alu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // action[3:0], dest_value[19:4], source_value[35:20], flags_in[51:36], zero pad
    input  logic [55:0] i_s_axis_tdata,
    // wide[0]
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // result_value[15:0], flags_out[31:16]
    output logic [31:0] o_m_axis_tdata,
    // write_back[0]
    output logic        o_m_axis_tuser
);

    // Pipeline advance enables
    logic en1, en2, en3;

    // Stage 1 registers: decoded operands
    logic                r_v1;
    t_alu_op             r1_op;
    logic                r1_wide;
    logic [WORD_W-1:0]   r1_d0;
    logic [WORD_W-1:0]   r1_d;
    logic [WORD_W-1:0]   r1_b;
    logic                r1_sub;
    logic [WORD_W-1:0]   r1_fl;
    logic [4:0]          r1_cnt;
    logic                r1_in_rng;
    logic                r1_cnt_one;
    logic [3:0]          r1_rot;
    logic [WORD_W-1:0]   r1_sx;
    logic [4:0]          r1_sh;

    logic [WORD_W-1:0]   n1_d0, n1_d, n1_s, n1_b, n1_fl, n1_sx;
    logic [CNT_W-1:0]    n1_cnt8;
    logic [4:0]          n1_bits;
    t_alu_op             n1_op;
    logic                n1_wide;

    // Stage 2 registers: raw result and carry / overflow
    logic                r_v2;
    logic                r2_wide;
    logic [BYTE_W-1:0]   r2_d_hi;
    logic [WORD_W-1:0]   r2_calc;
    logic [WORD_W-1:0]   r2_out;
    logic                r2_c;
    logic                r2_o;
    t_flag_mode          r2_mode;
    logic                r2_wb;
    logic [WORD_W-1:0]   r2_fl;

    logic [WORD_W-1:0]   n2_calc, n2_out;
    logic                n2_c, n2_o, n2_wb;
    t_flag_mode          n2_mode;

    // Stage 2 datapath intermediates
    logic [WORD_W-1:0]   mask, top;
    logic [WORD_W:0]     sum17;
    logic [WORD_W-1:0]   add_r;
    logic                add_c, add_o;
    logic [31:0]         rot_w_l, rot_w_r;
    logic [15:0]         rot_b_l, rot_b_r;
    logic [WORD_W-1:0]   rol_r, ror_r;
    logic [WORD_W:0]     shl_t, shr_t, sar_t;
    logic [WORD_W-1:0]   shl_r, shr_r, sar_r;
    logic                shl_c, shr_c;

    // Stage 3 registers: outgoing transaction
    logic                r_v3;
    logic [WORD_W-1:0]   r3_res;
    logic [WORD_W-1:0]   r3_fl;
    logic                r3_wb;

    logic [WORD_W-1:0]   n3_res, n3_fl;
    logic                sf_p, sf_z, sf_s;

    // Advance a stage when it is empty or the one after it moves
    assign en3 = !r_v3 || i_m_axis_tready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_s_axis_tready = en1;

    // Stage 1: unpack and decode operands
    always_comb begin
        n1_op   = t_alu_op'(i_s_axis_tdata[3:0]);
        n1_d0   = i_s_axis_tdata[19:4];
        n1_s    = i_s_axis_tdata[35:20];
        n1_fl   = i_s_axis_tdata[51:36];
        n1_wide = i_s_axis_tuser;
        n1_cnt8 = n1_s[CNT_W-1:0];
        n1_bits = n1_wide ? 5'd16 : 5'd8;
        n1_d    = n1_wide ? n1_d0 : {8'h00, n1_d0[BYTE_W-1:0]};
        n1_sx   = n1_wide ? n1_d0 : {{8{n1_d0[BYTE_W-1]}}, n1_d0[BYTE_W-1:0]};
        if ((n1_op == OP_INC) || (n1_op == OP_DEC)) begin
            n1_b = 16'h0001;
        end else if (n1_wide) begin
            n1_b = n1_s;
        end else begin
            n1_b = {8'h00, n1_s[BYTE_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_s_axis_tvalid;
        end
        if (en1) begin
            r1_op      <= n1_op;
            r1_wide    <= n1_wide;
            r1_d0      <= n1_d0;
            r1_d       <= n1_d;
            r1_b       <= n1_b;
            r1_sub     <= (n1_op == OP_SUB) || (n1_op == OP_CMP) || (n1_op == OP_DEC);
            r1_fl      <= n1_fl;
            r1_cnt     <= n1_cnt8[4:0];
            r1_in_rng  <= (n1_cnt8 <= {3'b000, n1_bits});
            r1_cnt_one <= (n1_cnt8 == 8'd1);
            r1_rot     <= n1_wide ? n1_cnt8[3:0] : {1'b0, n1_cnt8[2:0]};
            r1_sx      <= n1_sx;
            r1_sh      <= (n1_cnt8 > {3'b000, n1_bits}) ? n1_bits : n1_cnt8[4:0];
        end
    end

    // Stage 2: adder, rotator and shifters
    always_comb begin
        mask  = r1_wide ? 16'hFFFF : 16'h00FF;
        top   = r1_wide ? 16'h8000 : 16'h0080;

        sum17 = r1_sub ? ({1'b0, r1_d} - {1'b0, r1_b}) : ({1'b0, r1_d} + {1'b0, r1_b});
        add_r = sum17[WORD_W-1:0] & mask;
        add_c = (r1_sub || r1_wide) ? sum17[WORD_W] : sum17[BYTE_W];
        add_o = r1_sub ? (((r1_d ^ r1_b) & (r1_d ^ add_r) & top) != 16'h0000)
                       : (((r1_d ^ add_r) & (r1_b ^ add_r) & top) != 16'h0000);

        rot_w_l = {r1_d, r1_d} << r1_rot;
        rot_w_r = {r1_d, r1_d} >> r1_rot;
        rot_b_l = {r1_d[BYTE_W-1:0], r1_d[BYTE_W-1:0]} << r1_rot;
        rot_b_r = {r1_d[BYTE_W-1:0], r1_d[BYTE_W-1:0]} >> r1_rot;
        rol_r   = r1_wide ? rot_w_l[31:16] : {8'h00, rot_b_l[15:8]};
        ror_r   = r1_wide ? rot_w_r[15:0]  : {8'h00, rot_b_r[7:0]};

        shl_t = {1'b0, r1_d} << r1_cnt;
        shl_r = r1_in_rng ? (shl_t[WORD_W-1:0] & mask) : 16'h0000;
        shl_c = r1_in_rng && (r1_wide ? shl_t[WORD_W] : shl_t[BYTE_W]);

        shr_t = {r1_d, 1'b0} >> r1_cnt;
        shr_r = r1_in_rng ? shr_t[WORD_W:1] : 16'h0000;
        shr_c = r1_in_rng && shr_t[0];

        sar_t = 17'($signed({r1_sx, 1'b0}) >>> r1_sh);
        sar_r = sar_t[WORD_W:1] & mask;

        n2_calc = r1_d;
        n2_out  = r1_d;
        n2_c    = 1'b0;
        n2_o    = 1'b0;
        n2_mode = FM_KEEP;
        n2_wb   = 1'b1;
        case (r1_op)
            OP_ADD, OP_SUB: begin
                n2_calc = add_r;
                n2_out  = add_r;
                n2_c    = add_c;
                n2_o    = add_o;
                n2_mode = FM_ARITH;
            end
            OP_CMP: begin
                n2_calc = add_r;
                n2_c    = add_c;
                n2_o    = add_o;
                n2_mode = FM_ARITH;
                n2_wb   = 1'b0;
            end
            OP_INC, OP_DEC: begin
                n2_calc = add_r;
                n2_out  = add_r;
                n2_c    = r1_fl[FL_C];
                n2_o    = add_o;
                n2_mode = FM_ARITH;
            end
            OP_OR: begin
                n2_calc = r1_d | r1_b;
                n2_out  = r1_d | r1_b;
                n2_mode = FM_LOGIC;
            end
            OP_AND: begin
                n2_calc = r1_d & r1_b;
                n2_out  = r1_d & r1_b;
                n2_mode = FM_LOGIC;
            end
            OP_XOR: begin
                n2_calc = r1_d ^ r1_b;
                n2_out  = r1_d ^ r1_b;
                n2_mode = FM_LOGIC;
            end
            OP_ROL: begin
                n2_out  = rol_r;
            end
            OP_ROR: begin
                n2_out  = ror_r;
            end
            OP_SHL: begin
                n2_calc = shl_r;
                n2_out  = shl_r;
                n2_c    = shl_c;
                n2_o    = !r1_cnt_one || (((r1_d ^ shl_r) & top) != 16'h0000);
                n2_mode = FM_LOGIC;
            end
            OP_SHR: begin
                n2_calc = shr_r;
                n2_out  = shr_r;
                n2_c    = shr_c;
                n2_o    = r1_cnt_one && ((r1_d & top) != 16'h0000);
                n2_mode = FM_LOGIC;
            end
            OP_SAR: begin
                n2_calc = sar_r;
                n2_out  = sar_r;
                n2_c    = sar_t[0];
                n2_mode = FM_LOGIC;
            end
            default: begin
                // unused codes: pass destination through, no write-back
                n2_wb   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
        if (en2) begin
            r2_wide <= r1_wide;
            r2_d_hi <= r1_d0[WORD_W-1:BYTE_W];
            r2_calc <= n2_calc;
            r2_out  <= n2_out;
            r2_c    <= n2_c;
            r2_o    <= n2_o;
            r2_mode <= n2_mode;
            r2_wb   <= n2_wb;
            r2_fl   <= r1_fl;
        end
    end

    // Stage 3: sign, zero and parity, then assemble the flag word
    always_comb begin
        sf_p   = ~^r2_calc[BYTE_W-1:0];
        sf_z   = (r2_calc == 16'h0000);
        sf_s   = r2_wide ? r2_calc[WORD_W-1] : r2_calc[BYTE_W-1];
        n3_res = r2_wide ? r2_out : {r2_d_hi, r2_out[BYTE_W-1:0]};
        n3_fl  = r2_fl;
        case (r2_mode)
            FM_ARITH, FM_LOGIC: begin
                n3_fl[FL_O] = r2_o;
                n3_fl[FL_S] = sf_s;
                n3_fl[FL_Z] = sf_z;
                n3_fl[FL_P] = sf_p;
                n3_fl[FL_C] = r2_c;
                if (r2_mode == FM_ARITH) begin
                    n3_fl[FL_A] = 1'b0;
                end
            end
            default: begin
                n3_fl = r2_fl;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
        if (en3) begin
            r3_res <= n3_res;
            r3_fl  <= n3_fl;
            r3_wb  <= r2_wb;
        end
    end

    assign o_m_axis_tvalid = r_v3;
    assign o_m_axis_tdata  = {r3_fl, r3_res};
    assign o_m_axis_tuser  = r3_wb;

    // Input may only stall once every stage holds a transaction
    `ASSERT_SAME(a_ready_full, i_clk, i_rst_n, !o_s_axis_tready, r_v1 && r_v2 && r_v3, "input stalled with a free stage")
    // A stage-two transaction behind a stalled output must stay put
    `ASSERT_NEXT(a_hold_s2, i_clk, i_rst_n, r_v2 && r_v3 && !i_m_axis_tready, r_v2, "stage two transaction lost during stall")
    // A stage-one transaction that advances arrives in stage two
    `ASSERT_NEXT(a_move_s1, i_clk, i_rst_n, r_v1 && en2, r_v2, "stage one transaction lost on advance")

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking bench for the 8086-style ALU: directed and random transactions checked against a flag predictor
`timescale 1ns / 1ps

module testbench;
    import x86alu_pkg::*;

    // Action codes that the block leaves unused
    localparam logic [3:0] ACT_UNUSED_FIRST = 4'd13;
    localparam logic [3:0] ACT_UNUSED_LAST  = 4'd15;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int RANDOM_PER_PHASE = 650;
    localparam int DRAIN_CYCLES  = 10;

    typedef struct packed {
        logic [3:0]  action;
        logic        wide;
        logic [15:0] dest;
        logic [15:0] src;
        logic [15:0] flags;
    } alu_request_t;

    typedef struct packed {
        logic [15:0] result;
        logic [15:0] flags;
        logic        write_back;
    } alu_outcome_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [55:0] i_s_axis_tdata = '0;
    logic        i_s_axis_tuser = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;

    alu_request_t pending_ops[$];
    alu_outcome_t expected_outcomes[$];
    int           send_idle_pct = 27;
    int           recv_idle_pct = 81;
    int           fail_count = 0;
    int           cycle_count = 0;

    x86_alu_with_flags dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Clock: 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Set Z, S and P from a result held within the operation width
    function automatic logic [15:0] with_szp(input logic [15:0] fl, input int unsigned r,
                                             input int unsigned top);
        fl[FL_Z] = (r == 0);
        fl[FL_S] = ((r & top) != 0);
        fl[FL_P] = ~^r[7:0];
        return fl;
    endfunction

    // Add or subtract, rewriting O C Z S P and clearing A
    function automatic int unsigned add_or_subtract(input int unsigned d, input int unsigned s,
                                                    input bit subtract,
                                                    input int unsigned mask,
                                                    input int unsigned top,
                                                    inout logic [15:0] fl);
        int unsigned r;
        if (subtract) begin
            r = (d - s) & mask;
            fl[FL_O] = (((d ^ s) & (d ^ r) & top) != 0);
            fl[FL_C] = (d < s);
        end else begin
            r = (d + s) & mask;
            fl[FL_O] = (((d ^ r) & (s ^ r) & top) != 0);
            fl[FL_C] = ((d + s) > mask);
        end
        fl[FL_A] = 1'b0;
        fl = with_szp(fl, r, top);
        return r;
    endfunction

    // Work out result, flag word and write-back mark of one ALU transaction
    function automatic alu_outcome_t compute_alu_outcome(input alu_request_t q);
        alu_outcome_t o;
        int unsigned  mask, top, nbits, d, s, cnt, r, n, sx, sh, cs;
        logic [15:0]  fl;
        logic         carry_kept;
        mask  = q.wide ? 32'hFFFF : 32'hFF;
        top   = q.wide ? 32'h8000 : 32'h80;
        nbits = q.wide ? 16 : 8;
        d     = q.dest & mask;
        s     = q.src & mask;
        cnt   = q.src[7:0];
        r     = d;
        fl    = q.flags;
        o.write_back = 1'b1;
        case (q.action)
            OP_ADD: r = add_or_subtract(d, s, 1'b0, mask, top, fl);
            OP_SUB: r = add_or_subtract(d, s, 1'b1, mask, top, fl);
            OP_CMP: begin
                void'(add_or_subtract(d, s, 1'b1, mask, top, fl));
                o.write_back = 1'b0;
            end
            OP_OR, OP_AND, OP_XOR: begin
                if (q.action == OP_OR)
                    r = d | s;
                else if (q.action == OP_AND)
                    r = d & s;
                else
                    r = d ^ s;
                fl[FL_O] = 1'b0;
                fl[FL_C] = 1'b0;
                fl = with_szp(fl, r, top);
            end
            OP_INC, OP_DEC: begin
                carry_kept = fl[FL_C];
                r = add_or_subtract(d, 1, q.action == OP_DEC, mask, top, fl);
                fl[FL_C] = carry_kept;
            end
            OP_ROL: begin
                n = cnt % nbits;
                if (n != 0)
                    r = ((d << n) | (d >> (nbits - n))) & mask;
            end
            OP_ROR: begin
                n = cnt % nbits;
                if (n != 0)
                    r = ((d >> n) | (d << (nbits - n))) & mask;
            end
            OP_SHL: begin
                fl[FL_C] = (cnt >= 1) && (cnt <= nbits) && (((d >> (nbits - cnt)) & 1) != 0);
                r = (cnt < nbits) ? ((d << cnt) & mask) : 0;
                fl[FL_O] = (cnt != 1) || (((d ^ r) & top) != 0);
                fl = with_szp(fl, r, top);
            end
            OP_SHR: begin
                fl[FL_C] = (cnt >= 1) && (cnt <= nbits) && (((d >> (cnt - 1)) & 1) != 0);
                r = (cnt < nbits) ? (d >> cnt) : 0;
                fl[FL_O] = (cnt == 1) && ((d & top) != 0);
                fl = with_szp(fl, r, top);
            end
            OP_SAR: begin
                // Sign-extend to 32 bits so that the shift fills with the sign
                sx = ((d & top) != 0) ? (d | ~mask) : d;
                sh = (cnt > nbits) ? nbits : cnt;
                r = (sx >> sh) & mask;
                fl[FL_C] = 1'b0;
                if (cnt >= 1) begin
                    cs = (cnt - 1 > nbits) ? nbits : cnt - 1;
                    fl[FL_C] = (((sx >> cs) & 1) != 0);
                end
                fl[FL_O] = 1'b0;
                fl = with_szp(fl, r, top);
            end
            default: o.write_back = 1'b0;
        endcase
        o.result = (q.dest & ~mask[15:0]) | (r[15:0] & mask[15:0]);
        o.flags  = fl;
        return o;
    endfunction

    // Operand with a bias towards sign and width boundaries
    function automatic logic [15:0] pick_operand();
        logic [15:0] v;
        v = 16'($urandom);
        if ($urandom_range(3) == 0) begin
            case ($urandom_range(7))
                0: v = 16'h0000;
                1: v = 16'hFFFF;
                2: v = 16'h8000;
                3: v = 16'h7FFF;
                4: v = 16'h0080;
                5: v = 16'h007F;
                6: v = 16'h00FF;
                default: v = 16'h0001;
            endcase
            if ($urandom_range(1) == 1)
                v[15:8] = 8'($urandom);
        end
        return v;
    endfunction

    task automatic queue_op(input logic [3:0] action, input logic wide, input logic [15:0] dest,
                            input logic [15:0] src, input logic [15:0] flags);
        alu_request_t q;
        q.action = action;
        q.wide   = wide;
        q.dest   = dest;
        q.src    = src;
        q.flags  = flags;
        pending_ops.push_back(q);
    endtask

    task automatic queue_random_ops(input int count);
        logic [3:0]  action;
        logic        wide;
        logic [15:0] src;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 4)
                action = 4'($urandom_range(int'(ACT_UNUSED_FIRST), int'(ACT_UNUSED_LAST)));
            else
                action = 4'($urandom_range(int'(OP_SAR), int'(OP_ADD)));
            wide = 1'($urandom_range(1));
            src  = pick_operand();
            // Keep most shift counts around the width so every edge gets hit
            if (action >= OP_ROL && action <= OP_SAR && $urandom_range(99) < 80)
                src[7:0] = 8'($urandom_range(wide ? 17 : 9));
            queue_op(action, wide, pick_operand(), src, 16'($urandom));
        end
    endtask

    // Wait until every queued transaction is sent and every result has come back
    task automatic wait_until_drained();
        do
            @(negedge i_clk);
        while (pending_ops.size() != 0 || i_s_axis_tvalid || expected_outcomes.size() != 0);
    endtask

    // Input side: hold a presented transaction until taken, else present the next or idle
    always @(posedge i_clk) begin
        alu_request_t nxt;
        logic         fire;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            fire = i_s_axis_tvalid && o_s_axis_tready;
            if (fire)
                expected_outcomes.push_back(compute_alu_outcome(pending_ops.pop_front()));
            if (i_s_axis_tvalid && !fire) begin
                // hold the transaction on the bus
            end else if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_ops[0];
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {4'b0000, nxt.flags, nxt.src, nxt.dest, nxt.action};
                i_s_axis_tuser  <= nxt.wide;
            end else begin
                i_s_axis_tvalid <= 1'b0;
                i_s_axis_tdata  <= 56'({$urandom, $urandom});
                i_s_axis_tuser  <= 1'($urandom);
            end
        end
    end

    // Output side: check each result against the oldest expectation, stall at random
    always @(posedge i_clk) begin
        alu_outcome_t want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_outcomes.size() == 0) begin
                    $error("result with nothing expected: tdata=%h tuser=%b",
                           o_m_axis_tdata, o_m_axis_tuser);
                    fail_count++;
                end else begin
                    want = expected_outcomes.pop_front();
                    if (o_m_axis_tdata[15:0] !== want.result) begin
                        $error("result_value: expected %h, got %h",
                               want.result, o_m_axis_tdata[15:0]);
                        fail_count++;
                    end
                    if (o_m_axis_tdata[31:16] !== want.flags) begin
                        $error("flags_out: expected %h, got %h",
                               want.flags, o_m_axis_tdata[31:16]);
                        fail_count++;
                    end
                    if (o_m_axis_tuser !== want.write_back) begin
                        $error("write_back: expected %b, got %b",
                               want.write_back, o_m_axis_tuser);
                        fail_count++;
                    end
                end
            end
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: carries, overflows, width edges, zero and oversized counts
        queue_op(OP_ADD, 1'b1, 16'hFFFF, 16'h0001, 16'h0000);
        queue_op(OP_ADD, 1'b0, 16'h127F, 16'h0001, 16'hFFFF);
        queue_op(OP_SUB, 1'b0, 16'h0000, 16'h0001, 16'h0000);
        queue_op(OP_SUB, 1'b1, 16'h8000, 16'h0001, 16'h0000);
        queue_op(OP_CMP, 1'b1, 16'h1234, 16'h1234, 16'hFFFF);
        queue_op(OP_OR,  1'b1, 16'h0000, 16'h0000, 16'hFFFF);
        queue_op(OP_AND, 1'b0, 16'hAB55, 16'h00AA, 16'h0000);
        queue_op(OP_XOR, 1'b1, 16'hFFFF, 16'h7FFF, 16'hFFFF);
        queue_op(OP_INC, 1'b0, 16'h00FF, 16'h0000, 16'h0002);
        queue_op(OP_INC, 1'b1, 16'h7FFF, 16'hFFFF, 16'h0000);
        queue_op(OP_DEC, 1'b1, 16'h0000, 16'h0000, 16'h0000);
        queue_op(OP_DEC, 1'b0, 16'h0080, 16'h0000, 16'hFFFF);
        queue_op(OP_ROL, 1'b1, 16'h8001, 16'h0011, 16'h0000);
        queue_op(OP_ROR, 1'b0, 16'h0081, 16'h0000, 16'hFFFF);
        queue_op(OP_ROL, 1'b0, 16'h0081, 16'hFF08, 16'h0000);
        queue_op(OP_SHL, 1'b0, 16'h0081, 16'h0000, 16'hFFFF);
        queue_op(OP_SHL, 1'b0, 16'h0040, 16'h0001, 16'h0000);
        queue_op(OP_SHL, 1'b0, 16'h0081, 16'h0008, 16'h0000);
        queue_op(OP_SHL, 1'b1, 16'hFFFF, 16'h00FF, 16'h0000);
        queue_op(OP_SHR, 1'b1, 16'h8001, 16'h0001, 16'h0000);
        queue_op(OP_SHR, 1'b1, 16'h8000, 16'h0010, 16'hFFFF);
        queue_op(OP_SAR, 1'b0, 16'h0080, 16'h0009, 16'h0000);
        queue_op(OP_SAR, 1'b1, 16'h8000, 16'h00FF, 16'h0000);
        queue_op(OP_SAR, 1'b1, 16'h7FFF, 16'h0000, 16'hFFFF);
        queue_op(ACT_UNUSED_FIRST, 1'b1, 16'hBEEF, 16'h1234, 16'hA5A5);
        queue_op(ACT_UNUSED_LAST,  1'b0, 16'hCAFE, 16'h4321, 16'h5A5A);

        // Slow receiver, slow sender, then full rate; pause for the pipeline to empty between
        queue_random_ops(RANDOM_PER_PHASE);
        wait_until_drained();
        send_idle_pct = 81;
        recv_idle_pct = 27;
        queue_random_ops(RANDOM_PER_PHASE);
        wait_until_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_ops(RANDOM_PER_PHASE);
        wait_until_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && expected_outcomes.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
